// File: rtl/lcwe_pkg.sv
`default_nettype none

package lcwe_pkg;

    // Window size limit and field widths
    localparam int MAX_WINDOW = 32;
    localparam int SAMPLE_W   = 24;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 6;
    localparam int DIVR_W     = $clog2(MAX_WINDOW - 1);
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Shared divider: dividend and divisor widths
    localparam int DIV_NW = 39;
    localparam int DIV_DW = 25;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // Back-end arithmetic widths
    localparam int MAG_W  = SAMPLE_W + 1;
    localparam int CG_W   = DIV_NW;
    localparam int FAC_W  = 17;
    localparam int PROD_W = CG_W + FAC_W;

    // Job queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Constants
    localparam logic [13:0]         CG_PER_COUNT = 14'd10000;
    localparam logic [FAC_W-1:0]    Q16_GRAM     = 17'd65536;
    localparam logic [FAC_W-1:0]    Q16_KG       = 17'd66;
    localparam logic [FAC_W-1:0]    Q16_OZ       = 17'd2312;
    localparam logic [SAMPLE_W-1:0] CPG_RESET    = 24'd41200;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN   = 24'h80_0000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 24'h7F_FFFF;

    typedef enum logic [1:0] {
        JOB_MEASURE = 2'd0,
        JOB_TARE    = 2'd1,
        JOB_CAL     = 2'd2,
        JOB_UNIT    = 2'd3
    } job_kind_t;

    typedef enum logic [2:0] {
        RES_WEIGHT     = 3'd0,
        RES_TARE_DONE  = 3'd1,
        RES_CAL_OK     = 3'd2,
        RES_CAL_REJECT = 3'd3,
        RES_UNIT       = 3'd4
    } res_kind_t;

    typedef enum logic [1:0] {
        UNIT_G    = 2'd0,
        UNIT_KG   = 2'd1,
        UNIT_OZ   = 2'd2
    } unit_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEASURE_COUNT = 3'd0,
        CFG_TARE_COUNT    = 3'd1,
        CFG_CAL_COUNT     = 3'd2,
        CFG_ZERO_BAND     = 3'd3,
        CFG_CAL_MIN_DIFF  = 3'd4,
        CFG_OVL_HIGH      = 3'd5,
        CFG_OVL_LOW       = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DISPATCH,
        B_AVG_WAIT,
        B_APPLY,
        B_CG_MUL,
        B_CG_START,
        B_CG_WAIT,
        B_SCALE,
        B_ROUND,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]   measure_count;
        logic [CNT_W-1:0]   tare_count;
        logic [CNT_W-1:0]   cal_count;
        logic [15:0]        zero_band;
        logic [22:0]        cal_min_diff;
        logic [30:0]        overload_high_cg;
        logic signed [31:0] overload_low_cg;
    } cfg_t;

    typedef struct packed {
        job_kind_t          kind;
        logic signed [SUM_W-1:0] trimmed;
        logic [DIVR_W-1:0]  divisor;
    } job_t;

    // Window count limited to 3 .. MAX_WINDOW
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        if (n < CNT_W'(3)) begin
            r = CNT_W'(3);
        end else if (int'(n) > MAX_WINDOW) begin
            r = CNT_W'(MAX_WINDOW);
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lcwe_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle
module lcwe_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [lcwe_pkg::DIV_NW-1:0] dividend,
    input  wire logic [lcwe_pkg::DIV_DW-1:0] divisor,
    output logic                            done,
    output logic [lcwe_pkg::DIV_NW-1:0]     quotient
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [lcwe_pkg::DIV_CW-1:0]  cnt_reg, cnt_next;
    logic [lcwe_pkg::DIV_DW-1:0]  rem_reg, rem_next;
    logic [lcwe_pkg::DIV_NW-1:0]  quo_reg, quo_next;
    logic [lcwe_pkg::DIV_DW-1:0]  dsr_reg, dsr_next;

    logic [lcwe_pkg::DIV_DW:0]    rem_sh;
    logic [lcwe_pkg::DIV_DW:0]    rem_sub;
    logic                         ge;

    // One trial subtraction
    assign rem_sh  = {rem_reg, quo_reg[lcwe_pkg::DIV_NW-1]};
    assign ge      = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = lcwe_pkg::DIV_CW'(lcwe_pkg::DIV_NW);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[lcwe_pkg::DIV_DW-1:0] : rem_sh[lcwe_pkg::DIV_DW-1:0];
            quo_next = {quo_reg[lcwe_pkg::DIV_NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == lcwe_pkg::DIV_CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/lcwe_fifo.sv
`default_nettype none

// Short job queue between window front end and arithmetic back end
module lcwe_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lcwe_pkg::job_t  push_job,
    output logic                 full,
    input  wire logic            pop,
    output logic                 empty,
    output lcwe_pkg::job_t       head_job
);

    lcwe_pkg::job_t                 mem_reg [lcwe_pkg::FIFO_DEPTH];
    logic [lcwe_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lcwe_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lcwe_pkg::FIFO_CW-1:0]   count_reg, count_next;
    logic                           do_push, do_pop;

    assign full     = count_reg == lcwe_pkg::FIFO_CW'(lcwe_pkg::FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lcwe_front.sv
`default_nettype none

// Window tracking: open, accumulate sum/max/min, close into a job; unit steps are pushed directly
module lcwe_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lcwe_pkg::CMD_W-1:0]    cmd,
    input  wire logic [lcwe_pkg::SAMPLE_W-1:0] sample,
    input  wire lcwe_pkg::cfg_t                cfg,
    output logic                               push,
    output lcwe_pkg::job_t                     push_job,
    input  wire logic                          fifo_full
);

    localparam int EXT_W = lcwe_pkg::SUM_W - lcwe_pkg::SAMPLE_W;

    logic                               active_reg, active_next;
    lcwe_pkg::job_kind_t                kind_reg, kind_next;
    logic [lcwe_pkg::CNT_W-1:0]         idx_reg, idx_next;
    logic [lcwe_pkg::CNT_W-1:0]         len_reg, len_next;
    logic signed [lcwe_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic signed [lcwe_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic signed [lcwe_pkg::SAMPLE_W-1:0] min_reg, min_next;

    logic                               acc;
    logic signed [lcwe_pkg::SAMPLE_W-1:0] s;
    logic signed [lcwe_pkg::SUM_W-1:0]  s_ext, max_ext, min_ext;
    logic [lcwe_pkg::CNT_W-1:0]         open_len, len_m2;
    lcwe_pkg::job_kind_t                cmd_kind;

    assign in_ready = !fifo_full;
    assign acc      = in_valid && in_ready;
    assign s        = $signed(sample);
    assign s_ext    = {{EXT_W{sample[lcwe_pkg::SAMPLE_W-1]}}, sample};
    assign max_ext  = {{EXT_W{max_reg[lcwe_pkg::SAMPLE_W-1]}}, max_reg};
    assign min_ext  = {{EXT_W{min_reg[lcwe_pkg::SAMPLE_W-1]}}, min_reg};
    assign cmd_kind = lcwe_pkg::job_kind_t'(cmd);
    assign len_m2   = len_reg - lcwe_pkg::CNT_W'(2);

    // Count latched when a window opens
    always_comb begin
        case (cmd_kind)
            lcwe_pkg::JOB_MEASURE: open_len = lcwe_pkg::clamp_count(cfg.measure_count);
            lcwe_pkg::JOB_TARE:    open_len = lcwe_pkg::clamp_count(cfg.tare_count);
            lcwe_pkg::JOB_CAL:     open_len = lcwe_pkg::clamp_count(cfg.cal_count);
            default:               open_len = len_reg;
        endcase
    end

    // Window sequencing
    always_comb begin
        active_next = active_reg;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        push        = 1'b0;
        push_job.kind    = kind_reg;
        push_job.trimmed = sum_reg - max_ext - min_ext;
        push_job.divisor = len_m2[lcwe_pkg::DIVR_W-1:0];
        if (acc) begin
            if (!active_reg) begin
                if (cmd_kind == lcwe_pkg::JOB_UNIT) begin
                    // unit step goes straight to the back end
                    push          = 1'b1;
                    push_job.kind = lcwe_pkg::JOB_UNIT;
                end else begin
                    // opening sample is dropped
                    active_next = 1'b1;
                    kind_next   = cmd_kind;
                    len_next    = open_len;
                    idx_next    = lcwe_pkg::CNT_W'(1);
                    sum_next    = '0;
                    max_next    = $signed(lcwe_pkg::SAMPLE_MIN);
                    min_next    = $signed(lcwe_pkg::SAMPLE_MAX);
                end
            end else if (idx_reg <= len_reg) begin
                sum_next = sum_reg + s_ext;
                if (s > max_reg) begin
                    max_next = s;
                end
                if (s < min_reg) begin
                    min_next = s;
                end
                idx_next = idx_reg + 1'b1;
            end else begin
                // closing sample is dropped, window handed on
                push        = 1'b1;
                active_next = 1'b0;
                idx_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            kind_reg   <= lcwe_pkg::JOB_MEASURE;
            idx_reg    <= '0;
            len_reg    <= lcwe_pkg::CNT_W'(3);
            sum_reg    <= '0;
            max_reg    <= $signed(lcwe_pkg::SAMPLE_MIN);
            min_reg    <= $signed(lcwe_pkg::SAMPLE_MAX);
        end else begin
            active_reg <= active_next;
            kind_reg   <= kind_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            max_reg    <= max_next;
            min_reg    <= min_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lcwe_back.sv
`default_nettype none

// Job execution: trimmed mean, tare, calibration, weight and unit scaling
module lcwe_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire lcwe_pkg::cfg_t  cfg,
    input  wire logic            fifo_empty,
    input  wire lcwe_pkg::job_t  head_job,
    output logic                 fifo_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output lcwe_pkg::res_kind_t  m_kind,
    output logic signed [31:0]   m_disp,
    output lcwe_pkg::unit_t      m_unit,
    output logic                 m_ovl
);

    localparam int SW = lcwe_pkg::SAMPLE_W;
    localparam int NW = lcwe_pkg::DIV_NW;
    localparam int DW = lcwe_pkg::DIV_DW;

    lcwe_pkg::back_state_t      state_reg, state_next;

    lcwe_pkg::job_t             job_reg, job_next;
    logic signed [SW-1:0]       avg_reg, avg_next;
    logic                       sign_reg, sign_next;
    logic [lcwe_pkg::MAG_W-1:0] mag_reg, mag_next;
    logic [NW-1:0]              num_reg, num_next;
    logic [lcwe_pkg::CG_W-1:0]  cg_reg, cg_next;
    logic [lcwe_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                       ovl_reg, ovl_next;
    lcwe_pkg::res_kind_t        rkind_reg, rkind_next;
    logic signed [31:0]         rdisp_reg, rdisp_next;
    logic signed [SW-1:0]       tare_reg, tare_next;
    logic [SW-1:0]              cpg_reg, cpg_next;
    lcwe_pkg::unit_t            unit_reg, unit_next;

    logic                       mv_reg, mv_next;
    lcwe_pkg::res_kind_t        mk_reg;
    logic signed [31:0]         md_reg;
    lcwe_pkg::unit_t            mu_reg;
    logic                       mo_reg;

    logic                       div_start, div_done, out_load;
    logic [NW-1:0]              div_n, div_q;
    logic [DW-1:0]              div_d;

    logic [lcwe_pkg::SUM_W-1:0] trim_abs;
    logic [lcwe_pkg::SUM_W-1:0] avg_q;
    logic signed [SW:0]         diff;
    logic [lcwe_pkg::MAG_W-1:0] diff_abs;
    logic                       weigh;
    logic [NW:0]                num_full;
    logic [lcwe_pkg::FAC_W-1:0] factor;
    logic signed [lcwe_pkg::CG_W:0] cg_s;
    logic signed [lcwe_pkg::CG_W:0] high_ext, low_ext;
    logic [lcwe_pkg::PROD_W:0]  rnd_sum;
    logic [lcwe_pkg::CG_W:0]    rnd;
    logic signed [lcwe_pkg::CG_W+1:0] disp_w;
    logic [31:0]                disp_sat;

    // Shared divider for the mean and the centigram conversion
    lcwe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign trim_abs = job_reg.trimmed[lcwe_pkg::SUM_W-1] ? 
                      lcwe_pkg::SUM_W'(-job_reg.trimmed) : job_reg.trimmed;
    assign div_n    = (state_reg == lcwe_pkg::B_CG_START) ? num_reg : NW'(trim_abs);
    assign div_d    = (state_reg == lcwe_pkg::B_CG_START) ? {cpg_reg, 1'b0}
                                                          : DW'(job_reg.divisor);
    assign avg_q    = div_q[lcwe_pkg::SUM_W-1:0];

    // Difference to the tare offset
    assign diff     = {avg_reg[SW-1], avg_reg} - {tare_reg[SW-1], tare_reg};
    assign diff_abs = diff[SW] ? lcwe_pkg::MAG_W'(-diff) : lcwe_pkg::MAG_W'(diff);
    assign weigh    = (diff_abs >= lcwe_pkg::MAG_W'(cfg.zero_band)) && (cpg_reg != '0);

    // 2*|diff|*10000 + d, so that the quotient by 2d rounds half away from zero
    assign num_full = {(NW'(mag_reg) * NW'(lcwe_pkg::CG_PER_COUNT)), 1'b0}
                      + (NW + 1)'(cpg_reg);

    always_comb begin
        case (unit_reg)
            lcwe_pkg::UNIT_KG: factor = lcwe_pkg::Q16_KG;
            lcwe_pkg::UNIT_OZ: factor = lcwe_pkg::Q16_OZ;
            default:           factor = lcwe_pkg::Q16_GRAM;
        endcase
    end

    // Overload limits against the signed centigram value
    assign cg_s     = sign_reg ? -$signed({1'b0, cg_reg}) : $signed({1'b0, cg_reg});
    assign high_ext = $signed({{(lcwe_pkg::CG_W - 30){1'b0}}, cfg.overload_high_cg});
    assign low_ext  = {{(lcwe_pkg::CG_W - 31){cfg.overload_low_cg[31]}},
                       cfg.overload_low_cg};

    // Q16 rounding, sign and saturation
    assign rnd_sum  = {1'b0, prod_reg} + (lcwe_pkg::PROD_W + 1)'(32768);
    assign rnd      = rnd_sum[lcwe_pkg::CG_W + 16:16];
    assign disp_w   = sign_reg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    assign disp_sat = (disp_w[lcwe_pkg::CG_W+1:31] == {(lcwe_pkg::CG_W - 29){disp_w[lcwe_pkg::CG_W+1]}})
                      ? disp_w[31:0]
                      : (disp_w[lcwe_pkg::CG_W+1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lcwe_pkg::B_IDLE: begin
                if (!fifo_empty) state_next = lcwe_pkg::B_DISPATCH;
            end
            lcwe_pkg::B_DISPATCH: begin
                state_next = (job_reg.kind == lcwe_pkg::JOB_UNIT) ? lcwe_pkg::B_EMIT
                                                                  : lcwe_pkg::B_AVG_WAIT;
            end
            lcwe_pkg::B_AVG_WAIT: begin
                if (div_done) state_next = lcwe_pkg::B_APPLY;
            end
            lcwe_pkg::B_APPLY: begin
                if (job_reg.kind != lcwe_pkg::JOB_MEASURE) begin
                    state_next = lcwe_pkg::B_EMIT;
                end else if (weigh) begin
                    state_next = lcwe_pkg::B_CG_MUL;
                end else begin
                    state_next = lcwe_pkg::B_SCALE;
                end
            end
            lcwe_pkg::B_CG_MUL:   state_next = lcwe_pkg::B_CG_START;
            lcwe_pkg::B_CG_START: state_next = lcwe_pkg::B_CG_WAIT;
            lcwe_pkg::B_CG_WAIT: begin
                if (div_done) state_next = lcwe_pkg::B_SCALE;
            end
            lcwe_pkg::B_SCALE: state_next = lcwe_pkg::B_ROUND;
            lcwe_pkg::B_ROUND: state_next = lcwe_pkg::B_EMIT;
            lcwe_pkg::B_EMIT: begin
                if (out_load) state_next = lcwe_pkg::B_IDLE;
            end
            default: state_next = lcwe_pkg::B_IDLE;
        endcase
    end

    // Control strobes
    always_comb begin
        fifo_pop  = (state_reg == lcwe_pkg::B_IDLE) && !fifo_empty;
        div_start = ((state_reg == lcwe_pkg::B_DISPATCH) &&
                     (job_reg.kind != lcwe_pkg::JOB_UNIT)) ||
                    (state_reg == lcwe_pkg::B_CG_START);
        out_load  = (state_reg == lcwe_pkg::B_EMIT) && (!mv_reg || m_ready);
    end

    // Datapath
    always_comb begin
        job_next   = job_reg;
        avg_next   = avg_reg;
        sign_next  = sign_reg;
        mag_next   = mag_reg;
        num_next   = num_reg;
        cg_next    = cg_reg;
        prod_next  = prod_reg;
        ovl_next   = ovl_reg;
        rkind_next = rkind_reg;
        rdisp_next = rdisp_reg;
        tare_next  = tare_reg;
        cpg_next   = cpg_reg;
        unit_next  = unit_reg;
        case (state_reg)
            lcwe_pkg::B_IDLE: begin
                if (fifo_pop) job_next = head_job;
            end
            lcwe_pkg::B_DISPATCH: begin
                if (job_reg.kind == lcwe_pkg::JOB_UNIT) begin
                    case (unit_reg)
                        lcwe_pkg::UNIT_G:    unit_next = lcwe_pkg::UNIT_KG;
                        lcwe_pkg::UNIT_KG:   unit_next = lcwe_pkg::UNIT_OZ;
                        default:             unit_next = lcwe_pkg::UNIT_G;
                    endcase
                    rkind_next = lcwe_pkg::RES_UNIT;
                    rdisp_next = '0;
                    ovl_next   = 1'b0;
                end
            end
            lcwe_pkg::B_AVG_WAIT: begin
                if (div_done) begin
                    avg_next = job_reg.trimmed[lcwe_pkg::SUM_W-1] ?
                               $signed(SW'(-avg_q)) : $signed(SW'(avg_q));
                end
            end
            lcwe_pkg::B_APPLY: begin
                rdisp_next = '0;
                ovl_next   = 1'b0;
                sign_next  = diff[SW];
                mag_next   = diff_abs;
                cg_next    = '0;
                case (job_reg.kind)
                    lcwe_pkg::JOB_TARE: begin
                        tare_next  = avg_reg;
                        rkind_next = lcwe_pkg::RES_TARE_DONE;
                    end
                    lcwe_pkg::JOB_CAL: begin
                        if (diff > $signed({2'b00, cfg.cal_min_diff})) begin
                            cpg_next   = diff[SW-1:0];
                            rkind_next = lcwe_pkg::RES_CAL_OK;
                        end else begin
                            rkind_next = lcwe_pkg::RES_CAL_REJECT;
                        end
                    end
                    default: rkind_next = lcwe_pkg::RES_WEIGHT;
                endcase
            end
            lcwe_pkg::B_CG_MUL: begin
                num_next = num_full[NW-1:0];
            end
            lcwe_pkg::B_CG_WAIT: begin
                if (div_done) cg_next = div_q;
            end
            lcwe_pkg::B_SCALE: begin
                prod_next = lcwe_pkg::PROD_W'(cg_reg) * lcwe_pkg::PROD_W'(factor);
                ovl_next  = (cg_s > high_ext) || (cg_s < low_ext);
            end
            lcwe_pkg::B_ROUND: begin
                rdisp_next = $signed(disp_sat);
            end
            default: begin
            end
        endcase
    end

    // Output register: holds a finished result until taken
    always_comb begin
        mv_next = mv_reg;
        if (out_load) begin
            mv_next = 1'b1;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcwe_pkg::B_IDLE;
            tare_reg  <= '0;
            cpg_reg   <= lcwe_pkg::CPG_RESET;
            unit_reg  <= lcwe_pkg::UNIT_G;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            tare_reg  <= tare_next;
            cpg_reg   <= cpg_next;
            unit_reg  <= unit_next;
            mv_reg    <= mv_next;
        end
        job_reg   <= job_next;
        avg_reg   <= avg_next;
        sign_reg  <= sign_next;
        mag_reg   <= mag_next;
        num_reg   <= num_next;
        cg_reg    <= cg_next;
        prod_reg  <= prod_next;
        ovl_reg   <= ovl_next;
        rkind_reg <= rkind_next;
        rdisp_reg <= rdisp_next;
        if (out_load) begin
            mk_reg <= rkind_reg;
            md_reg <= rdisp_reg;
            mu_reg <= unit_reg;
            mo_reg <= ovl_reg;
        end
    end

    assign m_valid = mv_reg;
    assign m_kind  = mk_reg;
    assign m_disp  = md_reg;
    assign m_unit  = mu_reg;
    assign m_ovl   = mo_reg;

endmodule

`default_nettype wire

// File: rtl/load_cell_weigh_engine_core.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  tuser cmd, tdata sample
// m_        out        m_tvalid / m_tready  tuser kind, tdata value/unit/overload
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Samples are taken one per cycle while the two-entry job queue has room.
// Tare and calibration results take one pass of the 39-step shared divider, a weight
// two passes, or one when it falls inside the zero band; a unit change result needs
// no divider pass.
// Reset is synchronous and active low; it restores the control and configuration registers, tare, calibration and unit.
// A stalled m_tready holds the result register; the front keeps filling the queue.

module load_cell_weigh_engine_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,    // [23:0] sample
    input  wire logic [1:0]  s_tuser,    // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,    // [31:0] display_value, [33:32] unit, [34] overload
    output logic [2:0]       m_tuser,    // [2:0] kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    lcwe_pkg::cfg_t       cfg_reg, cfg_next;
    logic                 push, fifo_full, fifo_pop, fifo_empty;
    lcwe_pkg::job_t       push_job, head_job;
    lcwe_pkg::res_kind_t  m_kind;
    logic signed [31:0]   m_disp;
    lcwe_pkg::unit_t      m_unit;
    logic                 m_ovl;

    assign cfg_ready = 1'b1;

    // Configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (lcwe_pkg::cfg_index_t'(cfg_index))
                lcwe_pkg::CFG_MEASURE_COUNT: cfg_next.measure_count = cfg_data[5:0];
                lcwe_pkg::CFG_TARE_COUNT:    cfg_next.tare_count = cfg_data[5:0];
                lcwe_pkg::CFG_CAL_COUNT:     cfg_next.cal_count = cfg_data[5:0];
                lcwe_pkg::CFG_ZERO_BAND:     cfg_next.zero_band = cfg_data[15:0];
                lcwe_pkg::CFG_CAL_MIN_DIFF:  cfg_next.cal_min_diff = cfg_data[22:0];
                lcwe_pkg::CFG_OVL_HIGH:      cfg_next.overload_high_cg = cfg_data[30:0];
                lcwe_pkg::CFG_OVL_LOW:       cfg_next.overload_low_cg = $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.measure_count    <= 6'd5;
            cfg_reg.tare_count       <= 6'd10;
            cfg_reg.cal_count        <= 6'd20;
            cfg_reg.zero_band        <= 16'd50;
            cfg_reg.cal_min_diff     <= 23'd100;
            cfg_reg.overload_high_cg <= 31'd500000;
            cfg_reg.overload_low_cg  <= -32'sd10000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lcwe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd       (s_tuser),
        .sample    (s_tdata),
        .cfg       (cfg_reg),
        .push      (push),
        .push_job  (push_job),
        .fifo_full (fifo_full)
    );

    lcwe_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .empty    (fifo_empty),
        .head_job (head_job)
    );

    lcwe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .head_job   (head_job),
        .fifo_pop   (fifo_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_kind     (m_kind),
        .m_disp     (m_disp),
        .m_unit     (m_unit),
        .m_ovl      (m_ovl)
    );

    // Result packing
    assign m_tuser = m_kind;
    assign m_tdata = {5'd0, m_ovl, m_unit, m_disp};

endmodule

`default_nettype wire

// File: tb/load_cell_weigh_engine_core_tb.sv
`timescale 1ns / 1ps

module load_cell_weigh_engine_core_tb;
    import lcwe_pkg::*;

    localparam int PHASE_ITEMS   = 140;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 400000;

    // One result of the block, as the predictor expects it
    typedef struct {
        res_kind_t   kind;
        logic [31:0] value;
        unit_t       unit;
        logic        overload;
    } reading_t;

    // Predicts the weighing engine from accepted requests and checks its results
    class weigh_scoreboard;
        localparam longint KG_Q16 = 66;
        localparam longint OZ_Q16 = 2312;

        // register copy
        logic [5:0]         measure_count, tare_count, cal_count;
        logic [15:0]        zero_band;
        logic [22:0]        cal_min_diff;
        logic [30:0]        ovl_high;
        logic signed [31:0] ovl_low;

        // window and scale state
        bit                 window_open;
        job_kind_t          window_job;
        int                 span;
        int                 fill;
        longint             acc;
        logic signed [23:0] peak, trough;
        int                 offset;
        logic [23:0]        cpg;
        unit_t              unit;

        reading_t           due_readings[$];
        int                 mismatches;

        function new();
            measure_count = 6'd5;
            tare_count    = 6'd10;
            cal_count     = 6'd20;
            zero_band     = 16'd50;
            cal_min_diff  = 23'd100;
            ovl_high      = 31'd500000;
            ovl_low       = -32'sd10000;
            window_open   = 1'b0;
            window_job    = JOB_MEASURE;
            span          = 3;
            fill          = 0;
            acc           = 0;
            peak          = 24'sh800000;
            trough        = 24'sh7FFFFF;
            offset        = 0;
            cpg           = 24'd41200;
            unit          = UNIT_G;
            mismatches    = 0;
        endfunction

        function void apply_register(cfg_index_t idx, logic [31:0] value);
            case (idx)
                CFG_MEASURE_COUNT: measure_count = value[5:0];
                CFG_TARE_COUNT:    tare_count    = value[5:0];
                CFG_CAL_COUNT:     cal_count     = value[5:0];
                CFG_ZERO_BAND:     zero_band     = value[15:0];
                CFG_CAL_MIN_DIFF:  cal_min_diff  = value[22:0];
                CFG_OVL_HIGH:      ovl_high      = value[30:0];
                CFG_OVL_LOW:       ovl_low       = value;
                default: ;
            endcase
        endfunction

        function void note_request(job_kind_t cmd, logic signed [23:0] smp);
            longint   mean, diff, mag, num, q, cg, disp, factor;
            logic [5:0] n;
            reading_t r;
            // idle: a unit step, or the opening request of a window (its sample is dropped)
            if (!window_open) begin
                if (cmd == JOB_UNIT) begin
                    unit = (unit == UNIT_OZ) ? UNIT_G : unit_t'(unit + 2'd1);
                    r = '{RES_UNIT, 32'd0, unit, 1'b0};
                    due_readings.push_back(r);
                    return;
                end
                n = (cmd == JOB_MEASURE) ? measure_count :
                    (cmd == JOB_TARE) ? tare_count : cal_count;
                span = (n < 6'd3) ? 3 : (int'(n) > MAX_WINDOW) ? MAX_WINDOW : int'(n);
                window_open = 1'b1;
                window_job  = cmd;
                fill        = 1;
                acc         = 0;
                peak        = 24'sh800000;
                trough      = 24'sh7FFFFF;
                return;
            end
            // kept samples, whatever the command bits say
            if (fill <= span) begin
                acc += smp;
                if (smp > peak) peak = smp;
                if (smp < trough) trough = smp;
                fill++;
                return;
            end
            // closing sample: dropped, trimmed mean truncated toward zero
            mean = (acc - longint'(peak) - longint'(trough)) / longint'(span - 2);
            window_open = 1'b0;
            fill = 0;
            diff = mean - longint'(offset);
            r = '{RES_WEIGHT, 32'd0, unit, 1'b0};
            case (window_job)
                JOB_TARE: begin
                    offset = int'(mean);
                    r.kind = RES_TARE_DONE;
                end
                JOB_CAL: begin
                    if (diff > longint'(cal_min_diff)) begin
                        cpg = diff[23:0];
                        r.kind = RES_CAL_OK;
                    end else begin
                        r.kind = RES_CAL_REJECT;
                    end
                end
                default: begin
                    // centigrams rounded half away from zero, zero inside the band
                    mag = (diff < 0) ? -diff : diff;
                    cg = 0;
                    if (mag >= longint'(zero_band) && cpg != 24'd0) begin
                        num = diff * 10000;
                        mag = (num < 0) ? -num : num;
                        q = (2 * mag + longint'(cpg)) / (2 * longint'(cpg));
                        cg = (num < 0) ? -q : q;
                    end
                    r.overload = (cg > longint'(ovl_high)) || (cg < longint'(ovl_low));
                    factor = (unit == UNIT_KG) ? KG_Q16 : (unit == UNIT_OZ) ? OZ_Q16 : 0;
                    if (factor != 0) begin
                        mag = (cg < 0) ? -cg : cg;
                        q = (mag * factor + 32768) / 65536;
                        disp = (cg < 0) ? -q : q;
                    end else begin
                        disp = cg;
                    end
                    r.value = (disp > 64'sd2147483647) ? 32'h7FFF_FFFF :
                              (disp < -64'sd2147483648) ? 32'h8000_0000 : disp[31:0];
                end
            endcase
            due_readings.push_back(r);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [2:0] kind_bits, logic [39:0] data);
            reading_t want;
            if (due_readings.size() == 0) begin
                report($sformatf("result with none due, kind %0d value %0d",
                                 kind_bits, $signed(data[31:0])));
                return;
            end
            want = due_readings.pop_front();
            if (kind_bits !== want.kind)
                report($sformatf("kind %0d, want %0d", kind_bits, want.kind));
            if (data[31:0] !== want.value)
                report($sformatf("display value %0d, want %0d",
                                 $signed(data[31:0]), $signed(want.value)));
            if (data[33:32] !== want.unit)
                report($sformatf("unit %0d, want %0d", data[33:32], want.unit));
            if (data[34] !== want.overload)
                report($sformatf("overload %0b, want %0b", data[34], want.overload));
        endtask
    endclass

    // Directed opening: unit steps, extremes dropped at the window edges,
    // unit command inside a window, tare, accepted and rejected calibration
    localparam job_kind_t DIRECTED_CMDS [23] = '{
        JOB_UNIT,
        JOB_MEASURE, JOB_UNIT, JOB_TARE, JOB_CAL, JOB_MEASURE,
        JOB_TARE, JOB_MEASURE, JOB_TARE, JOB_CAL, JOB_UNIT,
        JOB_CAL, JOB_MEASURE, JOB_MEASURE, JOB_MEASURE, JOB_MEASURE,
        JOB_CAL, JOB_MEASURE, JOB_MEASURE, JOB_MEASURE, JOB_MEASURE,
        JOB_UNIT, JOB_UNIT
    };
    localparam int DIRECTED_SAMPLES [23] = '{
        8388607,
        8388607, -8388608, 8388607, 1000, -8388608,
        -5, -100, -120, -110, 8388607,
        0, 41090, 41100, 41110, 0,
        0, -100, -90, -110, 0,
        0, 0
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    weigh_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  send_quiet    = 1'b0;
    bit  hold_pending  = 1'b0;
    bit  pause_done    = 1'b0;
    int  phase_items   = 0;
    int  cycle_count   = 0;

    load_cell_weigh_engine_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Register write; caller lowers cfg_valid after the last one
    task cfg_write(cfg_index_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.apply_register(idx, value);
    endtask

    task configure(int mcount, int tcount, int ccount, int band, int min_diff,
                   int high, int low);
        cfg_write(CFG_MEASURE_COUNT, mcount);
        cfg_write(CFG_TARE_COUNT, tcount);
        cfg_write(CFG_CAL_COUNT, ccount);
        cfg_write(CFG_ZERO_BAND, band);
        cfg_write(CFG_CAL_MIN_DIFF, min_diff);
        cfg_write(CFG_OVL_HIGH, high);
        cfg_write(CFG_OVL_LOW, low);
        cfg_valid <= 1'b0;
    endtask

    // Idle cycles drawn one at a time, then one request on the sample channel
    task send_item(job_kind_t cmd, logic [23:0] smp);
        if (!send_quiet) begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, smp);
        phase_items++;
    endtask

    // Raw level a window is built around; measure and calibration levels are relative to the current tare
    function automatic int pick_level(job_kind_t job);
        int pick, anywhere, base;
        pick     = $urandom_range(0, 9);
        anywhere = int'($urandom) >>> 8;
        base     = sb.offset;
        if (pick == 0) return anywhere;
        case (job)
            JOB_TARE: return int'($urandom_range(0, 600000)) - 300000;
            JOB_CAL:  return (pick < 3) ? base + int'($urandom_range(0, 200)) :
                                          base + int'($urandom_range(1000, 400000));
            default: begin
                if (pick < 3) return base + int'($urandom_range(0, 200)) - 100;
                if (pick < 6) return base + int'($urandom_range(0, 1000000)) - 500000;
                return base + int'($urandom_range(0, 40000)) - 20000;
            end
        endcase
    endfunction

    // Sample near the level, with the odd spike or rail value
    function automatic logic [23:0] noisy(int level);
        longint v;
        int pick;
        pick = $urandom_range(0, 39);
        if (pick == 0) return 24'h800000;
        if (pick == 1) return 24'h7FFFFF;
        if (pick < 4) return 24'($urandom);
        v = longint'(level) + longint'($urandom_range(0, 400)) - 200;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    // Whole window; command bits inside it are random and must be ignored
    task run_window(job_kind_t job);
        int level;
        level = pick_level(job);
        send_item(job, noisy(level));
        while (sb.window_open) send_item(job_kind_t'($urandom_range(0, 3)), noisy(level));
    endtask

    task drain();
        while (sb.due_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Result side: random stalls in stretches, plus one long hold-off on request
    initial begin
        int stretch_left;
        int hold_left;
        bit steady;
        stretch_left = 0;
        hold_left    = 0;
        steady       = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_left    = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(20, 80);
                    steady       = ($urandom_range(0, 3) == 0);
                end
                stretch_left--;
                m_tready <= steady || ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int r;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part with the shortest windows
        send_idle_pct = 25;
        recv_idle_pct = 63;
        configure(3, 3, 3, 50, 100, 500000, -10000);
        for (int i = 0; i < 23; i++) send_item(DIRECTED_CMDS[i], 24'(DIRECTED_SAMPLES[i]));
        s_tvalid <= 1'b0;
        drain();

        // random phases, each under its own register setting
        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 25 : (p < 4) ? 63 : 0;
            recv_idle_pct = (p < 2) ? 63 : (p < 4) ? 25 : 0;
            case (p)
                0: configure(4, 5, 6, 50, 100, 500000, -10000);
                // counts below the floor, all limits at zero
                1: configure(0, 1, 2, 0, 0, 0, 0);
                // counts at and above the ceiling, limits wide open
                2: configure(32, 63, 33, 65535, 8388607, 2147483647,
                             int'(32'h8000_0000));
                3: configure(3, 3, 3, $urandom_range(1, 200), $urandom_range(100, 3000),
                             $urandom_range(1000, 900000), -int'($urandom_range(1, 900000)));
                4: configure($urandom_range(3, 8), $urandom_range(3, 8), $urandom_range(3, 8),
                             $urandom_range(0, 300), $urandom_range(0, 5000),
                             $urandom_range(0, 2000000), -int'($urandom_range(0, 2000000)));
                default: configure(5, 4, 3, 10, 50, 100000, -100000);
            endcase
            // block the result side long enough for the request side to back up
            if (p == 4) hold_pending = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if (p == 5 && !pause_done && phase_items >= PHASE_ITEMS / 2) begin
                    pause_done = 1'b1;
                    s_tvalid <= 1'b0;
                    do @(posedge aclk); while (sb.due_readings.size() != 0);
                end
                send_quiet = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 9);
                if (r < 2) begin
                    send_item(JOB_UNIT, 24'($urandom));
                end else begin
                    run_window(job_kind_t'(r % 3));
                end
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/lcwe_pkg.sv
rtl/lcwe_div.sv
rtl/lcwe_fifo.sv
rtl/lcwe_front.sv
rtl/lcwe_back.sv
rtl/load_cell_weigh_engine_core.sv
tb/load_cell_weigh_engine_core_tb.sv
